>>> design/ccsl_pkg.sv
// ----------------------------------------------------------------------------
// ccsl_pkg
// Shared types and constants for the comment stripper with lowering.
// ----------------------------------------------------------------------------
`default_nettype none

package ccsl_pkg;

  localparam logic [7:0] SLASH_CH   = 8'h2F;
  localparam logic [7:0] STAR_CH    = 8'h2A;
  localparam logic [7:0] NEWLINE_CH = 8'h0A;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  // Scan mode, one-hot
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_BLOCK  = 3'b010,
    MODE_LINE   = 3'b100
  } scan_mode_t;

  // Bytes produced by one input word: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] first;
    logic [7:0] second;
  } emit_t;

endpackage

`default_nettype wire

>>> design/ccsl_if.sv
// ----------------------------------------------------------------------------
// ccsl_in_if / ccsl_out_if
// Valid/ready channels for raw text input and stripped text output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface ccsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

>>> design/c_comment_stripper_lowercase.sv
// ----------------------------------------------------------------------------
// c_comment_stripper_lowercase
// Strips C block and line comments from a byte stream and lowers A-Z.
// ----------------------------------------------------------------------------
//
//   channel   role   payload                    words per handshake
//   text_in   sink   in_byte[7:0], end_of_text  one raw text byte
//   text_out  source out_byte[7:0], run_last    one kept byte
//
// Each accepted word is held in the input register, then the scanner
// decides its 0..2 output bytes and loads them into the result slot.
// For words giving one byte or none, a new word is taken every cycle
// while text_out keeps up. A word giving two bytes (a released slash
// and the byte after it) holds the result slot until both are sent.
// Reset (rst, synchronous) empties both registers, sets normal mode and
// clears the held slash. A stall on text_out holds the slot, then the input
// register, then drops text_in.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module c_comment_stripper_lowercase (
  input  wire logic   clk,
  input  wire logic   rst,
  ccsl_in_if.sink     text_in,
  ccsl_out_if.source  text_out
);

  logic            q_valid;
  logic [7:0]      q_byte;
  logic            q_eot;
  ccsl_pkg::emit_t emit;
  logic            slot_free;
  logic            advance;

  // Advance the registered word when it emits nothing or the slot can take it
  assign advance       = q_valid && ((emit.count == 2'd0) || slot_free);
  assign text_in.ready = !q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (text_in.ready) begin
      q_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      q_byte <= text_in.in_byte;
      q_eot  <= text_in.end_of_text;
    end
  end

  ccsl_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .in_byte     (q_byte),
    .end_of_text (q_eot),
    .emit        (emit)
  );

  // Load only words that produce bytes
  ccsl_out_slot u_slot (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && (emit.count != 2'd0)),
    .emit     (emit),
    .free     (slot_free),
    .text_out (text_out)
  );

endmodule

`default_nettype wire

>>> design/ccsl_scan.sv
// ----------------------------------------------------------------------------
// ccsl_scan
// Comment scanner: holds mode and delimiter state, decides the bytes to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsl_scan (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic [7:0]     in_byte,
  input  wire logic           end_of_text,
  output ccsl_pkg::emit_t     emit
);

  ccsl_pkg::scan_mode_t mode, mode_next;
  logic                 held, held_next;

  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    if (b >= ccsl_pkg::UPPER_A && b <= ccsl_pkg::UPPER_Z) begin
      return b + ccsl_pkg::CASE_GAP;
    end
    return b;
  endfunction

  always_comb begin
    mode_next   = mode;
    held_next   = held;
    emit.count  = 2'd0;
    emit.first  = lower_ascii(in_byte);
    emit.second = lower_ascii(in_byte);

    unique case (mode)
      ccsl_pkg::MODE_BLOCK: begin
        if (held && in_byte == ccsl_pkg::SLASH_CH) begin
          mode_next = ccsl_pkg::MODE_NORMAL;
          held_next = 1'b0;
        end else begin
          held_next = (in_byte == ccsl_pkg::STAR_CH);
        end
      end
      ccsl_pkg::MODE_LINE: begin
        held_next = 1'b0;
        if (in_byte == ccsl_pkg::NEWLINE_CH) begin
          emit.count = 2'd1;
          emit.first = ccsl_pkg::NEWLINE_CH;
          mode_next  = ccsl_pkg::MODE_NORMAL;
        end
      end
      default: begin
        mode_next = ccsl_pkg::MODE_NORMAL;
        if (held) begin
          held_next = 1'b0;
          priority if (in_byte == ccsl_pkg::STAR_CH) begin
            mode_next = ccsl_pkg::MODE_BLOCK;
          end else if (in_byte == ccsl_pkg::SLASH_CH) begin
            mode_next = ccsl_pkg::MODE_LINE;
          end else begin
            // release the held slash ahead of this byte
            emit.count = 2'd2;
            emit.first = ccsl_pkg::SLASH_CH;
          end
        end else if (in_byte == ccsl_pkg::SLASH_CH) begin
          if (end_of_text) begin
            emit.count = 2'd1;
          end else begin
            held_next = 1'b1;
          end
        end else begin
          emit.count = 2'd1;
        end
      end
    endcase

    if (end_of_text) begin
      mode_next = ccsl_pkg::MODE_NORMAL;
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ccsl_pkg::MODE_NORMAL;
      held <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

>>> design/ccsl_out_slot.sv
// ----------------------------------------------------------------------------
// ccsl_out_slot
// Result register: holds the bytes of one input word and sends them in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsl_out_slot (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire ccsl_pkg::emit_t emit,
  output logic                 free,
  ccsl_out_if.source           text_out
);

  logic [1:0] remain;
  logic [7:0] head;
  logic [7:0] tail;
  logic       fire;

  assign fire              = text_out.valid && text_out.ready;
  assign free              = (remain == 2'd0) || (remain == 2'd1 && text_out.ready);
  assign text_out.valid    = (remain != 2'd0);
  assign text_out.out_byte = head;
  assign text_out.run_last = (remain == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 2'd0;
    end else if (load) begin
      remain <= emit.count;
    end else if (fire) begin
      remain <= remain - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= emit.first;
      tail <= emit.second;
    end else if (fire) begin
      head <= tail;
    end
  end

endmodule

`default_nettype wire
